### src/gfst_pkg.sv
package gfst_pkg;

	localparam int unsigned TicksW = 20;
	localparam int unsigned CountW = 8;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] CFG_PULSE_HALF_PERIOD = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PULSE_COUNT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_POLL_INTERVAL = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_BLEED_TIME = 3'd4;

	localparam logic [TicksW-1:0] RST_PULSE_HALF_PERIOD = 20'd8333;
	localparam logic [CountW-1:0] RST_PULSE_COUNT = 8'd100;
	localparam logic [TicksW-1:0] RST_POLL_INTERVAL = 20'd10000;
	localparam logic [CountW-1:0] RST_POLL_LIMIT = 8'd255;
	localparam logic [TicksW-1:0] RST_BLEED_TIME = 20'd500000;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_PULSE     = 5'b00010,
		PH_POLL      = 5'b00100,
		PH_POLL_WAIT = 5'b01000,
		PH_BLEED     = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [TicksW-1:0] pulse_half_period;
		logic [CountW-1:0] pulse_count;
		logic [TicksW-1:0] poll_interval;
		logic [CountW-1:0] poll_limit;
		logic [TicksW-1:0] bleed_time;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic              previous_sense;
		logic              trip_flag;
		logic              drive_level;
		logic [TicksW-1:0] interval_ticks;
		logic [CountW-1:0] pulse_index;
		logic [CountW-1:0] poll_index;
	} seq_state_t;

	typedef struct packed {
		logic test_drive;
		logic trip_latched;
		logic busy_res;
		logic trip_event;
		logic test_done;
		logic test_passed;
	} result_t;

endpackage

### src/gfst_step.sv
module gfst_step
	import gfst_pkg::*;
(
	input  cfg_t       cfg,
	input  seq_state_t cur,
	input  logic       command,
	input  logic       sense,
	output seq_state_t nxt,
	output result_t    res
);

	logic [TicksW-1:0] half_min;
	logic [TicksW-1:0] poll_min;
	logic [TicksW-1:0] ticks_inc;
	logic [CountW-1:0] pulse_inc;
	logic              event_now;
	logic              done_now;
	logic              passed_now;

	assign half_min = (cfg.pulse_half_period == '0) ? TicksW'(1) : cfg.pulse_half_period;
	assign poll_min = (cfg.poll_interval == '0) ? TicksW'(1) : cfg.poll_interval;
	assign ticks_inc = cur.interval_ticks + TicksW'(1);
	assign pulse_inc = cur.pulse_index + CountW'(1);

	always_comb begin
		nxt = cur;
		event_now = 1'b0;
		done_now = 1'b0;
		passed_now = 1'b0;

		if (sense && !cur.previous_sense && !cur.trip_flag) begin
			nxt.trip_flag = 1'b1;
			if (cur.phase == PH_IDLE) begin
				event_now = 1'b1;
			end
		end
		nxt.previous_sense = sense;

		case (cur.phase)
			PH_IDLE: begin
				if (command) begin
					if (nxt.trip_flag) begin
						done_now = 1'b1;
					end else if (cfg.pulse_count == '0) begin
						nxt.drive_level = 1'b0;
						nxt.phase = PH_POLL;
						nxt.poll_index = '0;
						nxt.interval_ticks = '0;
					end else begin
						nxt.phase = PH_PULSE;
						nxt.pulse_index = '0;
						nxt.interval_ticks = '0;
						nxt.drive_level = !cur.drive_level;
					end
				end
			end
			PH_PULSE: begin
				nxt.interval_ticks = ticks_inc;
				if (ticks_inc >= half_min) begin
					nxt.pulse_index = pulse_inc;
					if (pulse_inc != cfg.pulse_count && !nxt.trip_flag) begin
						nxt.drive_level = !cur.drive_level;
						nxt.interval_ticks = '0;
					end else begin
						nxt.drive_level = 1'b0;
						nxt.phase = PH_POLL;
						nxt.poll_index = '0;
						nxt.interval_ticks = '0;
					end
				end
			end
			PH_POLL, PH_POLL_WAIT: begin
				if (cur.phase == PH_POLL_WAIT) begin
					nxt.interval_ticks = ticks_inc;
				end
				if (cur.phase == PH_POLL || ticks_inc >= poll_min) begin
					nxt.interval_ticks = '0;
					if (cur.poll_index >= cfg.poll_limit || !sense) begin
						nxt.phase = PH_BLEED;
						if (cfg.bleed_time == '0) begin
							done_now = 1'b1;
							passed_now = nxt.trip_flag && !sense;
							nxt.trip_flag = 1'b0;
							nxt.drive_level = 1'b0;
							nxt.phase = PH_IDLE;
						end
					end else begin
						nxt.poll_index = cur.poll_index + CountW'(1);
						nxt.phase = PH_POLL_WAIT;
					end
				end
			end
			PH_BLEED: begin
				nxt.interval_ticks = ticks_inc;
				if (ticks_inc >= cfg.bleed_time) begin
					done_now = 1'b1;
					passed_now = nxt.trip_flag && !sense;
					nxt.trip_flag = 1'b0;
					nxt.drive_level = 1'b0;
					nxt.phase = PH_IDLE;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
				nxt.drive_level = 1'b0;
			end
		endcase

		res.test_drive = nxt.drive_level;
		res.trip_latched = nxt.trip_flag;
		res.busy_res = (nxt.phase != PH_IDLE);
		res.trip_event = event_now;
		res.test_done = done_now;
		res.test_passed = passed_now;
	end

endmodule

### src/ground_fault_self_test_sequencer.sv
// Channel   Signals                                Direction
// input     in_valid, in_ready, command, sense     request in
// output    out_valid, out_ready, six result bits  request out
// config    cfg_we, cfg_index, cfg_data            write only
//
// Each request is one timebase tick; the next-state logic sits between the
// sequencer state registers and the result register.
// A new request is taken while the result register is empty or being drained,
// so a tick can enter in every cycle. Reset clears the sequencer to idle and
// loads the default register values. A stalled output holds its result and
// blocks input until it is taken.
module ground_fault_self_test_sequencer
	import gfst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic               sense,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               test_drive,
	output logic               trip_latched,
	output logic               busy_res,
	output logic               trip_event,
	output logic               test_done,
	output logic               test_passed,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TicksW-1:0]  cfg_data
);

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       out_valid_q;
	logic       accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	gfst_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.command (command),
		.sense   (sense),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_half_period <= RST_PULSE_HALF_PERIOD;
			cfg_q.pulse_count <= RST_PULSE_COUNT;
			cfg_q.poll_interval <= RST_POLL_INTERVAL;
			cfg_q.poll_limit <= RST_POLL_LIMIT;
			cfg_q.bleed_time <= RST_BLEED_TIME;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PULSE_HALF_PERIOD: cfg_q.pulse_half_period <= cfg_data;
				CFG_PULSE_COUNT: cfg_q.pulse_count <= cfg_data[CountW-1:0];
				CFG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_data;
				CFG_POLL_LIMIT: cfg_q.poll_limit <= cfg_data[CountW-1:0];
				CFG_BLEED_TIME: cfg_q.bleed_time <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.previous_sense <= 1'b0;
			state_q.trip_flag <= 1'b0;
			state_q.drive_level <= 1'b0;
			state_q.interval_ticks <= '0;
			state_q.pulse_index <= '0;
			state_q.poll_index <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign test_drive = res_q.test_drive;
	assign trip_latched = res_q.trip_latched;
	assign busy_res = res_q.busy_res;
	assign trip_event = res_q.trip_event;
	assign test_done = res_q.test_done;
	assign test_passed = res_q.test_passed;

endmodule
